// ----- hdl/thc_pkg.sv -----
// Shared types and constants of the thermostat heat/cool controller.
package thc_pkg;

	localparam int unsigned TEMP_W  = 12;
	localparam int unsigned HYST_W  = 8;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_COOL = 2'd1,
		MODE_HEAT = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COOL_SETPOINT = 3'd0,
		CFG_HEAT_SETPOINT = 3'd1,
		CFG_HYSTERESIS    = 3'd2,
		CFG_MIN_COOL_ON   = 3'd3,
		CFG_MIN_HEAT_ON   = 3'd4,
		CFG_MIN_COOL_OFF  = 3'd5,
		CFG_MIN_HEAT_OFF  = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] cool_setpoint;
		logic signed [TEMP_W-1:0] heat_setpoint;
		logic [HYST_W-1:0]        hysteresis;
		logic [COUNT_W-1:0]       min_cool_on;
		logic [COUNT_W-1:0]       min_heat_on;
		logic [COUNT_W-1:0]       min_cool_off;
		logic [COUNT_W-1:0]       min_heat_off;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		logic  settling;
	} status_t;

endpackage

// ----- hdl/thc_if.sv -----
// Valid/ready channel interfaces for input items and status results.
interface thc_in_if;
	logic              valid;
	logic              ready;
	logic              func;
	logic signed [11:0] temperature;

	modport source (output valid, output func, output temperature, input ready);
	modport sink (input valid, input func, input temperature, output ready);
endinterface

interface thc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic       cool_drive;
	logic       heat_drive;
	logic       calibrating;

	modport source (output valid, output mode, output cool_drive, output heat_drive,
		output calibrating, input ready);
	modport sink (input valid, input mode, input cool_drive, input heat_drive,
		input calibrating, output ready);
endinterface

// ----- hdl/thc_cfg_regs.sv -----
// Configuration register file written through a plain write port.
module thc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_data,
	output thc_pkg::cfg_t                 cfg
);
	import thc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cool_setpoint <= 12'sd250;
			cfg_q.heat_setpoint <= 12'sd200;
			cfg_q.hysteresis    <= 8'd5;
			cfg_q.min_cool_on   <= 16'd300;
			cfg_q.min_heat_on   <= 16'd300;
			cfg_q.min_cool_off  <= 16'd300;
			cfg_q.min_heat_off  <= 16'd300;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_COOL_SETPOINT: cfg_q.cool_setpoint <= $signed(cfg_data[TEMP_W-1:0]);
				CFG_HEAT_SETPOINT: cfg_q.heat_setpoint <= $signed(cfg_data[TEMP_W-1:0]);
				CFG_HYSTERESIS:    cfg_q.hysteresis    <= cfg_data[HYST_W-1:0];
				CFG_MIN_COOL_ON:   cfg_q.min_cool_on   <= cfg_data[COUNT_W-1:0];
				CFG_MIN_HEAT_ON:   cfg_q.min_heat_on   <= cfg_data[COUNT_W-1:0];
				CFG_MIN_COOL_OFF:  cfg_q.min_cool_off  <= cfg_data[COUNT_W-1:0];
				CFG_MIN_HEAT_OFF:  cfg_q.min_heat_off  <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- hdl/thc_core.sv -----
// Thermostat state and its combinational update for one input item.
module thc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step,
	input  logic                              func,
	input  logic signed [thc_pkg::TEMP_W-1:0] temperature,
	input  thc_pkg::cfg_t                     cfg,
	output thc_pkg::status_t                  status_next
);
	import thc_pkg::*;

	localparam int unsigned DIFF_W = TEMP_W + 1;
	localparam int unsigned CMP_W  = TEMP_W + 2;

	mode_t                    mode_q, mode_n;
	logic                     settling_q, settling_n;
	logic signed [TEMP_W-1:0] last_q, last_n;
	logic [COUNT_W-1:0]       secs_q, secs_n, secs_inc;
	logic signed [DIFF_W-1:0] diff;
	logic signed [CMP_W-1:0]  t_ext, cool_ext, heat_ext, cool_lo, heat_hi;

	assign secs_inc = (secs_q == COUNT_MAX) ? secs_q : secs_q + COUNT_W'(1);
	assign diff     = {last_q[TEMP_W-1], last_q} - {temperature[TEMP_W-1], temperature};
	assign t_ext    = {{2{last_q[TEMP_W-1]}}, last_q};
	assign cool_ext = {{2{cfg.cool_setpoint[TEMP_W-1]}}, cfg.cool_setpoint};
	assign heat_ext = {{2{cfg.heat_setpoint[TEMP_W-1]}}, cfg.heat_setpoint};
	assign cool_lo  = cool_ext - $signed({{(CMP_W-HYST_W){1'b0}}, cfg.hysteresis});
	assign heat_hi  = heat_ext + $signed({{(CMP_W-HYST_W){1'b0}}, cfg.hysteresis});

	always_comb begin
		mode_n     = mode_q;
		settling_n = settling_q;
		last_n     = last_q;
		secs_n     = secs_q;
		if (step) begin
			if (!func) begin
				if (diff >= -DIFF_W'(1) && diff <= DIFF_W'(1)) begin
					settling_n = 1'b0;
				end
				last_n = temperature;
			end else begin
				secs_n = secs_inc;
				if (!settling_q) begin
					case (mode_q)
						MODE_COOL: begin
							if (secs_inc >= cfg.min_cool_on && t_ext < cool_lo) begin
								mode_n = MODE_OFF;
								secs_n = '0;
							end
						end
						MODE_HEAT: begin
							if (secs_inc >= cfg.min_heat_on && t_ext > heat_hi) begin
								mode_n = MODE_OFF;
								secs_n = '0;
							end
						end
						default: begin
							if (t_ext > cool_ext && secs_inc >= cfg.min_cool_off) begin
								mode_n = MODE_COOL;
								secs_n = '0;
							end else if (t_ext < heat_ext && secs_inc >= cfg.min_heat_off) begin
								mode_n = MODE_HEAT;
								secs_n = '0;
							end
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			settling_q <= 1'b1;
			last_q     <= '0;
			secs_q     <= '0;
		end else begin
			mode_q     <= mode_n;
			settling_q <= settling_n;
			last_q     <= last_n;
			secs_q     <= secs_n;
		end
	end

	assign status_next.mode     = mode_n;
	assign status_next.settling = settling_n;

	// Cooling and heating always pass through off.
	a_no_cool_to_heat: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_COOL) |=> (mode_q != MODE_HEAT))
		else $error("mode went from cooling straight to heating");

	a_no_heat_to_cool: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_HEAT) |=> (mode_q != MODE_COOL))
		else $error("mode went from heating straight to cooling");

	// Every transition restarts the elapsed-time counter.
	a_restart_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(mode_q) |-> (secs_q == '0))
		else $error("counter not restarted on a mode transition");

	// Once settled, the block never returns to calibrating.
	a_settled_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		!settling_q |=> !settling_q)
		else $error("calibrating flag set again");

	// No transition is evaluated while calibrating.
	a_hold_while_settling: assert property (@(posedge clk) disable iff (!arst_n)
		settling_q |=> $stable(mode_q))
		else $error("mode changed while calibrating");

endmodule

// ----- hdl/thermostat_heat_cool_controller_top.sv -----
// Top level of the thermostat heat/cool controller.
//
//   Channel   Direction  Handshake     Contents
//   sample    in         valid/ready   func, temperature
//   status    out        valid/ready   mode, cool_drive, heat_drive, calibrating
//   cfg_*     in         write enable  cfg_index, cfg_data
//
// Each item passes through the input register, then the state update into the output
// register; one item per cycle is sustained while the status channel does not stall.
// Reset returns all but the data registers to their defaults at once; there is no clearing pass.
// A stalled status channel holds the result and the input register, and sample.ready
// drops only when both stages are full.
module thermostat_heat_cool_controller_top (
	input  logic                          clk,
	input  logic                          arst_n,
	thc_in_if.sink                        sample,
	thc_out_if.source                     status,
	input  logic                          cfg_write,
	input  logic [thc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [thc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import thc_pkg::*;

	cfg_t                     cfg;
	status_t                  status_next;
	status_t                  status_q;
	logic                     out_valid_q;
	logic                     valid_s1;
	logic                     func_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	logic                     advance;
	logic                     step;

	assign advance      = !out_valid_q || status.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			func_s1 <= sample.func;
			temp_s1 <= sample.temperature;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			status_q <= status_next;
		end
	end

	thc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	thc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.func        (func_s1),
		.temperature (temp_s1),
		.cfg         (cfg),
		.status_next (status_next)
	);

	assign status.valid       = out_valid_q;
	assign status.mode        = status_q.mode;
	assign status.cool_drive  = (status_q.mode == MODE_COOL);
	assign status.heat_drive  = (status_q.mode == MODE_HEAT);
	assign status.calibrating = status_q.settling;

endmodule

// ----- dv/thc_status_board_pkg.sv -----
// Scoreboard class that predicts the thermostat status results and checks them.
package thc_status_board_pkg;
	import thc_pkg::*;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_TICK   = 1'b1;

	typedef struct {
		mode_t mode;
		logic  cool_drive;
		logic  heat_drive;
		logic  calibrating;
	} status_expect_t;

	class thc_status_board;
		int cool_setpoint;
		int heat_setpoint;
		int hysteresis;
		int min_cool_on;
		int min_heat_on;
		int min_cool_off;
		int min_heat_off;
		mode_t mode;
		int last_temperature;
		bit settling;
		int seconds_in_mode;
		status_expect_t expected_q[$];
		int mismatches;

		function new();
			cool_setpoint = 250;
			heat_setpoint = 200;
			hysteresis = 5;
			min_cool_on = 300;
			min_heat_on = 300;
			min_cool_off = 300;
			min_heat_off = 300;
			mode = MODE_OFF;
			last_temperature = 0;
			settling = 1'b1;
			seconds_in_mode = 0;
			mismatches = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			logic signed [TEMP_W-1:0] setpoint;
			setpoint = data[TEMP_W-1:0];
			case (index)
			CFG_COOL_SETPOINT: cool_setpoint = setpoint;
			CFG_HEAT_SETPOINT: heat_setpoint = setpoint;
			CFG_HYSTERESIS:    hysteresis = data[HYST_W-1:0];
			CFG_MIN_COOL_ON:   min_cool_on = data;
			CFG_MIN_HEAT_ON:   min_heat_on = data;
			CFG_MIN_COOL_OFF:  min_cool_off = data;
			CFG_MIN_HEAT_OFF:  min_heat_off = data;
			default: ;
			endcase
		endfunction

		function void enter_mode(mode_t next_mode);
			mode = next_mode;
			seconds_in_mode = 0;
		endfunction

		function void note_input(logic func, logic signed [TEMP_W-1:0] temperature);
			int t;
			status_expect_t e;
			t = temperature;
			if (func == FUNC_SAMPLE) begin
				if (last_temperature - t >= -1 && last_temperature - t <= 1)
					settling = 1'b0;
				last_temperature = t;
			end else begin
				if (seconds_in_mode < int'(COUNT_MAX))
					seconds_in_mode++;
				if (!settling) begin
					case (mode)
					MODE_COOL: begin
						if (seconds_in_mode >= min_cool_on &&
								last_temperature < cool_setpoint - hysteresis)
							enter_mode(MODE_OFF);
					end
					MODE_HEAT: begin
						if (seconds_in_mode >= min_heat_on &&
								last_temperature > heat_setpoint + hysteresis)
							enter_mode(MODE_OFF);
					end
					default: begin
						if (last_temperature > cool_setpoint && seconds_in_mode >= min_cool_off)
							enter_mode(MODE_COOL);
						else if (last_temperature < heat_setpoint &&
								seconds_in_mode >= min_heat_off)
							enter_mode(MODE_HEAT);
					end
					endcase
				end
			end
			e.mode = mode;
			e.cool_drive = (mode == MODE_COOL);
			e.heat_drive = (mode == MODE_HEAT);
			e.calibrating = settling;
			expected_q.push_back(e);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("status error: %s", what);
		endfunction

		function void compare_field(string name, logic [1:0] got, logic [1:0] want);
			if (got !== want)
				flag($sformatf("%s expected %0d, got %0d", name, want, got));
		endfunction

		function void check_status(logic [1:0] got_mode, logic got_cool, logic got_heat,
				logic got_cal);
			status_expect_t e;
			if (expected_q.size() == 0) begin
				flag("status transfer with no result outstanding");
				return;
			end
			e = expected_q.pop_front();
			compare_field("mode", got_mode, e.mode);
			compare_field("cool_drive", {1'b0, got_cool}, {1'b0, e.cool_drive});
			compare_field("heat_drive", {1'b0, got_heat}, {1'b0, e.heat_drive});
			compare_field("calibrating", {1'b0, got_cal}, {1'b0, e.calibrating});
		endfunction

		function void flag_leftovers();
			if (expected_q.size() != 0)
				flag($sformatf("%0d results never arrived", expected_q.size()));
		endfunction
	endclass

endpackage

// ----- dv/thermostat_heat_cool_controller_top_test.sv -----
// Testbench top: directed and random items through the thermostat controller, checked by a scoreboard.
module thermostat_heat_cool_controller_top_test;
	import thc_pkg::*;
	import thc_status_board_pkg::*;

	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 80;
	localparam int HOLD_CYCLES = 60;
	localparam logic [CFG_IDX_W-1:0] CFG_BAD_INDEX = 3'd7;

	typedef struct {
		logic                     func;
		logic signed [TEMP_W-1:0] temperature;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic status_hold = 1'b0;

	thc_status_board board;
	sample_item_t item_q[$];
	int items_queued = 0;
	int items_accepted = 0;
	int send_idle_pct = 34;
	int recv_idle_pct = 46;
	int cycle_count = 0;

	thc_in_if sample_ch();
	thc_out_if status_ch();

	thermostat_heat_cool_controller_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.status    (status_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : sample_driver
		logic taken;
		sample_ch.valid = 1'b0;
		sample_ch.func = FUNC_SAMPLE;
		sample_ch.temperature = '0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			taken = sample_ch.valid && sample_ch.ready;
			if (taken) begin
				board.note_input(sample_ch.func, sample_ch.temperature);
				void'(item_q.pop_front());
				items_accepted++;
			end
			@(negedge clk);
			if (!sample_ch.valid || taken) begin
				if (item_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					sample_ch.valid = 1'b1;
					sample_ch.func = item_q[0].func;
					sample_ch.temperature = item_q[0].temperature;
				end else begin
					sample_ch.valid = 1'b0;
					sample_ch.func = 1'($urandom);
					sample_ch.temperature = 12'($urandom);
				end
			end
		end
	end

	initial begin : status_receiver
		status_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (status_ch.valid === 1'b1 && status_ch.ready)
				board.check_status(status_ch.mode, status_ch.cool_drive, status_ch.heat_drive,
					status_ch.calibrating);
			@(negedge clk);
			status_ch.ready = !status_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic hold_status(int cycles);
		status_hold = 1'b1;
		repeat (cycles) @(posedge clk);
		status_hold = 1'b0;
	endtask

	task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_write = 1'b0;
		board.write_register(index, data);
	endtask

	task automatic queue_item(logic func, logic signed [TEMP_W-1:0] temperature);
		item_q.push_back('{func, temperature});
		items_queued++;
	endtask

	task automatic wait_drained();
		while (items_accepted != items_queued || board.expected_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int clamp_temperature(int t);
		if (t < -500)
			return -500;
		if (t > 1500)
			return 1500;
		return t;
	endfunction

	function automatic int pick_min_time();
		case ($urandom_range(19))
		0: return $urandom_range(65535);
		1: return 0;
		default: return $urandom_range(6);
		endcase
	endfunction

	task automatic randomize_config(output int cool_sp, output int heat_sp, output int hyst);
		heat_sp = int'($urandom_range(1400)) - 500;
		if ($urandom_range(4) == 0)
			cool_sp = clamp_temperature(heat_sp - int'($urandom_range(60)));
		else
			cool_sp = clamp_temperature(heat_sp + int'($urandom_range(100)));
		hyst = ($urandom_range(9) == 0) ? int'($urandom_range(255)) : int'($urandom_range(20));
		write_register(CFG_COOL_SETPOINT, 16'(cool_sp));
		write_register(CFG_HEAT_SETPOINT, 16'(heat_sp));
		write_register(CFG_HYSTERESIS, 16'(hyst));
		write_register(CFG_MIN_COOL_ON, 16'(pick_min_time()));
		write_register(CFG_MIN_HEAT_ON, 16'(pick_min_time()));
		write_register(CFG_MIN_COOL_OFF, 16'(pick_min_time()));
		write_register(CFG_MIN_HEAT_OFF, 16'(pick_min_time()));
	endtask

	task automatic queue_random_items(int count, int cool_sp, int heat_sp, int hyst);
		int walk;
		walk = heat_sp + int'($urandom_range(40)) - 20;
		repeat (count) begin
			if ($urandom_range(99) < 55) begin
				queue_item(FUNC_TICK, 12'($urandom));
			end else begin
				case ($urandom_range(9))
				0: walk = int'($urandom_range(2000)) - 500;
				1: walk = cool_sp + int'($urandom_range(2 * hyst + 8)) - hyst - 4;
				2: walk = heat_sp + int'($urandom_range(2 * hyst + 8)) - hyst - 4;
				default: walk = walk + int'($urandom_range(30)) - 15;
				endcase
				walk = clamp_temperature(walk);
				queue_item(FUNC_SAMPLE, 12'(walk));
			end
		end
	endtask

	initial begin : main_sequence
		int cool_sp;
		int heat_sp;
		int hyst;
		board = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Ticks while calibrating advance the counter without changing the mode; a first
		// sample within one tenth of zero settles at once, and the next tick starts heating.
		write_register(CFG_MIN_HEAT_OFF, 16'd6);
		write_register(CFG_BAD_INDEX, 16'd0);
		repeat (5) queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_SAMPLE, 12'sd1);
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_SAMPLE, 12'sd1500);
		wait_drained();

		write_register(CFG_MIN_COOL_ON, 16'd0);
		write_register(CFG_MIN_HEAT_ON, 16'd0);
		write_register(CFG_MIN_COOL_OFF, 16'd0);
		write_register(CFG_MIN_HEAT_OFF, 16'd0);
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_SAMPLE, -12'sd500);
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		// With crossed setpoints both start conditions hold and cooling wins.
		write_register(CFG_COOL_SETPOINT, 16'd100);
		write_register(CFG_HEAT_SETPOINT, 16'd300);
		write_register(CFG_HYSTERESIS, 16'd0);
		queue_item(FUNC_SAMPLE, 12'sd1500);
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_SAMPLE, 12'sd200);
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		write_register(CFG_COOL_SETPOINT, 16'(-500));
		write_register(CFG_HEAT_SETPOINT, 16'd1500);
		write_register(CFG_HYSTERESIS, 16'd255);
		write_register(CFG_MIN_COOL_ON, 16'hFFFF);
		write_register(CFG_MIN_HEAT_ON, 16'hFFFF);
		write_register(CFG_MIN_COOL_OFF, 16'hFFFF);
		write_register(CFG_MIN_HEAT_OFF, 16'hFFFF);
		queue_item(FUNC_SAMPLE, -12'sd500);
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		// The setpoint minus the hysteresis must not wrap, so cooling holds.
		write_register(CFG_MIN_COOL_ON, 16'd0);
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		write_register(CFG_HYSTERESIS, 16'd0);
		write_register(CFG_COOL_SETPOINT, 16'd0);
		write_register(CFG_MIN_HEAT_OFF, 16'd0);
		queue_item(FUNC_TICK, 12'($urandom));
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		// The setpoint plus the hysteresis must not wrap, so heating holds.
		write_register(CFG_HYSTERESIS, 16'd255);
		write_register(CFG_MIN_HEAT_ON, 16'd0);
		queue_item(FUNC_SAMPLE, 12'sd1500);
		queue_item(FUNC_TICK, 12'($urandom));
		wait_drained();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase < RANDOM_PHASES / 3) begin
				send_idle_pct = 34;
				recv_idle_pct = 46;
			end else if (phase < 2 * RANDOM_PHASES / 3) begin
				send_idle_pct = 46;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			randomize_config(cool_sp, heat_sp, hyst);
			queue_random_items(PHASE_ITEMS, cool_sp, heat_sp, hyst);
			if (phase == 2 || phase == 9) begin
				fork
					hold_status(HOLD_CYCLES);
				join_none
			end
			wait_drained();
		end

		board.flag_leftovers();
		if (board.mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- thermostat_heat_cool_controller_top.f -----
hdl/thc_pkg.sv
hdl/thc_if.sv
hdl/thc_cfg_regs.sv
hdl/thc_core.sv
hdl/thermostat_heat_cool_controller_top.sv
dv/thc_status_board_pkg.sv
dv/thermostat_heat_cool_controller_top_test.sv
